// ----- rtl/core/ghsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle slot allocator: shared definitions
// Request codes, decoded operations, status codes, the item carried between
// the front and the back end, and the back end state type.
// ----------------------------------------------------------------------------
package ghsa_pkg;

    // Field widths fixed by the handle format.
    localparam int unsigned INDEX_W = 8;
    localparam int unsigned GEN_W   = 32;
    localparam int unsigned COUNT_W = 9;

    // Request codes as they arrive on the request channel.
    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // Decoded operation.
    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_LOOKUP
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_OPEN = 2'd2,
        ST_STALE    = 2'd3
    } t_status;

    // Classified request held in the queue.
    typedef struct packed {
        t_op                op;
        logic [INDEX_W-1:0] index;
        logic [GEN_W-1:0]   generation;
    } t_item;

    // Back end sequencer states.
    typedef enum logic {
        BK_READ,
        BK_EXEC
    } t_back_state;

    // Pool occupancy reported by the back end.
    typedef struct packed {
        logic [COUNT_W-1:0] opened;
        logic [COUNT_W-1:0] region;
    } t_pool_stat;

endpackage

// ----- rtl/core/ghsa_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one allocator request per transfer.
// ----------------------------------------------------------------------------
interface ghsa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  in_index;
    logic [31:0] in_generation;

    modport source (output valid, output req_type, output in_index,
                    output in_generation, input ready);
    modport sink   (input valid, input req_type, input in_index,
                    input in_generation, output ready);
endinterface

// ----- rtl/core/ghsa_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one allocator result per transfer.
// ----------------------------------------------------------------------------
interface ghsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  out_index;
    logic [31:0] out_generation;

    modport source (output valid, output status, output out_index,
                    output out_generation, input ready);
    modport sink   (input valid, input status, input out_index,
                    input out_generation, output ready);
endinterface

// ----- rtl/core/generational_handle_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// Generational handle slot allocator
// A request passes the front holding register, the queue, the back end read
// registers and the response register. The back end reads the generation and
// link memories for one request, then updates them before taking the next.
// Reset: synchronous, active low; clears the stack, counters and channels.
// The slot memories are not cleared; an entry is read only after a write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module generational_handle_slot_allocator #(
    parameter int unsigned SLOTS_PER_BLOCK = 32,
    parameter int unsigned NUM_BLOCKS      = 8,
    parameter int unsigned GEN_BITS        = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ghsa_req_if.sink   i_req,
    ghsa_rsp_if.source o_rsp
);

    logic                 front_valid;
    ghsa_pkg::t_item      front_item;
    logic                 queue_ready;
    logic                 head_valid;
    ghsa_pkg::t_item      head_item;
    logic                 head_pop;
    ghsa_pkg::t_pool_stat pool_stat;

    // Request decode and holding register.
    ghsa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_q_valid (front_valid),
        .o_q_item  (front_item),
        .i_q_ready (queue_ready)
    );

    // Decoupling queue.
    ghsa_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_item  (front_item),
        .o_push_ready (queue_ready),
        .o_head_valid (head_valid),
        .o_head_item  (head_item),
        .i_pop        (head_pop)
    );

    // Pool state and execution.
    ghsa_back #(
        .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
        .NUM_BLOCKS      (NUM_BLOCKS),
        .GEN_BITS        (GEN_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (head_valid),
        .i_q_item  (head_item),
        .o_q_pop   (head_pop),
        .o_rsp     (o_rsp),
        .o_stat    (pool_stat)
    );

`ifndef SYNTHESIS
    // Every slot handed out lies inside the opened region.
    a_opened_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pool_stat.opened <= pool_stat.region)
        else $error("opened slot count exceeds opened region");

    // The region is opened exactly when the first slot is handed out.
    a_region_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pool_stat.opened == '0) == (pool_stat.region == '0))
        else $error("opened region out of step with slot count");

    // A successful result always carries a live, nonzero generation.
    a_ok_nonzero_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ghsa_pkg::ST_OK) |-> (o_rsp.out_generation != '0))
        else $error("ok result with zero generation");

    // A pool-full result returns the null handle.
    a_full_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ghsa_pkg::ST_FULL)
            |-> (o_rsp.out_index == '0 && o_rsp.out_generation == '0))
        else $error("pool-full result with non-null handle");
`endif

endmodule

// ----- rtl/core/ghsa_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator front end
// Accepts requests, decodes the request code into an operation and holds the
// classified item in a register until the queue takes it.
// ----------------------------------------------------------------------------
module ghsa_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ghsa_req_if.sink        i_req,
    output logic            o_q_valid,
    output ghsa_pkg::t_item o_q_item,
    input  logic            i_q_ready
);

    logic            r_valid;
    ghsa_pkg::t_item r_item;
    ghsa_pkg::t_op   dec_op;

    // The register may be refilled in the cycle its contents move on.
    assign i_req.ready = !r_valid || i_q_ready;

    // Decode the request code; the unused code behaves as a lookup.
    always_comb begin
        unique case (i_req.req_type)
            ghsa_pkg::REQ_ALLOC: dec_op = ghsa_pkg::OP_ALLOC;
            ghsa_pkg::REQ_FREE:  dec_op = ghsa_pkg::OP_FREE;
            default:             dec_op = ghsa_pkg::OP_LOOKUP;
        endcase
    end

    // Valid flag of the holding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    // Payload of the holding register.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item.op         <= dec_op;
            r_item.index      <= i_req.in_index;
            r_item.generation <= i_req.in_generation;
        end
    end

    assign o_q_valid = r_valid;
    assign o_q_item  = r_item;

endmodule

// ----- rtl/core/ghsa_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-entry request queue
// Decouples the front end from the back end so that each can stall alone.
// ----------------------------------------------------------------------------
module ghsa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  ghsa_pkg::t_item i_push_item,
    output logic            o_push_ready,
    output logic            o_head_valid,
    output ghsa_pkg::t_item o_head_item,
    input  logic            i_pop
);

    ghsa_pkg::t_item r_entry [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head_item  = r_entry[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_head_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ----- rtl/core/ghsa_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator back end
// Holds the free stack, the pool counters and the per-slot generation and
// link memories. Each request is read in the read state and carried out in the
// execute state, which waits until the response register can take its result.
// ----------------------------------------------------------------------------
module ghsa_back #(
    parameter int unsigned SLOTS_PER_BLOCK = 32,
    parameter int unsigned NUM_BLOCKS      = 8,
    parameter int unsigned GEN_BITS        = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  ghsa_pkg::t_item      i_q_item,
    output logic                 o_q_pop,
    ghsa_rsp_if.source           o_rsp,
    output ghsa_pkg::t_pool_stat o_stat
);

    localparam int unsigned RAW_SLOTS  = SLOTS_PER_BLOCK * NUM_BLOCKS;
    localparam int unsigned POOL_SLOTS = (RAW_SLOTS < 256) ? RAW_SLOTS : 256;
    localparam int unsigned IDX_W      = $clog2(POOL_SLOTS);
    localparam int unsigned BLK_W      = $clog2(SLOTS_PER_BLOCK);
    localparam int unsigned SUM_W      = $clog2(256 + SLOTS_PER_BLOCK + 1);
    localparam int unsigned CNT_W      = ghsa_pkg::COUNT_W;
    localparam int unsigned GW         = ghsa_pkg::GEN_W;
    localparam int unsigned IW         = ghsa_pkg::INDEX_W;

    // Slot memories: generation and free-stack link (valid bit over index).
    logic [GEN_BITS-1:0] r_gen_mem  [POOL_SLOTS];
    logic [IDX_W:0]      r_link_mem [POOL_SLOTS];
    logic [GEN_BITS-1:0] r_gen_rd;
    logic [IDX_W:0]      r_link_rd;

    // Sequencer and request being worked on.
    ghsa_pkg::t_back_state r_state, n_state;
    ghsa_pkg::t_op         r_op;
    logic [IW-1:0]         r_idx;
    logic [GW-1:0]         r_gen;

    // Pool state.
    logic [IDX_W-1:0] r_top, n_top;
    logic             r_nonempty, n_nonempty;
    logic [CNT_W-1:0] r_opened, n_opened;
    logic [CNT_W-1:0] r_region, n_region;
    logic [BLK_W-1:0] r_blk, n_blk;

    // Response register.
    logic                r_out_valid;
    ghsa_pkg::t_status   r_out_status;
    logic [IW-1:0]       r_out_index;
    logic [GW-1:0]       r_out_gen;

    // Execution signals.
    logic                exec;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_gen_en;
    logic                wr_link_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [GEN_BITS-1:0] wr_gen_data;
    ghsa_pkg::t_status   res_status;
    logic [IW-1:0]       res_index;
    logic [GW-1:0]       res_gen;
    logic                in_region;
    logic                in_opened;
    logic [GW-1:0]       stored_gen;
    logic [GW-1:0]       look_gen;
    logic [GEN_BITS-1:0] gen_inc;
    logic [GEN_BITS-1:0] gen_next;
    logic [SUM_W-1:0]    region_sum;

    // Classification against the pool counters.
    assign in_region  = ({1'b0, r_idx} < r_region);
    assign in_opened  = ({1'b0, r_idx} < r_opened);
    assign stored_gen = GW'(r_gen_rd);
    assign look_gen   = in_opened ? stored_gen : GW'(1);

    // Next generation after a free, wrapping past zero to one.
    assign gen_inc  = r_gen[GEN_BITS-1:0] + 1'b1;
    assign gen_next = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

    // Opened region grows by one block, capped at the pool size.
    assign region_sum = SUM_W'(r_region) + SUM_W'(SLOTS_PER_BLOCK);

    // An allocation reads the stack top, anything else its own slot.
    assign rd_addr = (i_q_item.op == ghsa_pkg::OP_ALLOC) ? r_top
                                                         : i_q_item.index[IDX_W-1:0];

    // Sequencer: next state, memory writes and the result.
    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        exec        = 1'b0;
        n_top       = r_top;
        n_nonempty  = r_nonempty;
        n_opened    = r_opened;
        n_region    = r_region;
        n_blk       = r_blk;
        wr_gen_en   = 1'b0;
        wr_link_en  = 1'b0;
        wr_addr     = r_idx[IDX_W-1:0];
        wr_gen_data = gen_next;
        res_status  = ghsa_pkg::ST_OK;
        res_index   = r_idx;
        res_gen     = '0;
        unique case (r_state)
            ghsa_pkg::BK_READ: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = ghsa_pkg::BK_EXEC;
                end
            end
            ghsa_pkg::BK_EXEC: begin
                if (!r_out_valid || o_rsp.ready) begin
                    exec    = 1'b1;
                    n_state = ghsa_pkg::BK_READ;
                    unique case (r_op)
                        ghsa_pkg::OP_ALLOC: begin
                            if (r_nonempty) begin
                                // Pop the most recently freed slot.
                                res_index  = IW'(r_top);
                                res_gen    = stored_gen;
                                n_top      = r_link_rd[IDX_W-1:0];
                                n_nonempty = r_link_rd[IDX_W];
                            end else if (r_opened < CNT_W'(POOL_SLOTS)) begin
                                // Hand out a fresh slot at generation one.
                                res_index   = r_opened[IW-1:0];
                                res_gen     = GW'(1);
                                wr_gen_en   = 1'b1;
                                wr_addr     = r_opened[IDX_W-1:0];
                                wr_gen_data = GEN_BITS'(1);
                                n_opened    = r_opened + 1'b1;
                                if (r_blk == '0) begin
                                    n_region = (region_sum >= SUM_W'(POOL_SLOTS))
                                             ? CNT_W'(POOL_SLOTS) : region_sum[CNT_W-1:0];
                                end
                                n_blk = (r_blk == BLK_W'(SLOTS_PER_BLOCK - 1))
                                      ? '0 : r_blk + 1'b1;
                            end else begin
                                res_status = ghsa_pkg::ST_FULL;
                                res_index  = '0;
                            end
                        end
                        ghsa_pkg::OP_FREE: begin
                            if (!in_region || !in_opened) begin
                                res_status = ghsa_pkg::ST_NOT_OPEN;
                            end else if (stored_gen != r_gen) begin
                                res_status = ghsa_pkg::ST_STALE;
                                res_gen    = stored_gen;
                            end else begin
                                // Advance the generation and push the slot.
                                res_gen    = GW'(gen_next);
                                wr_gen_en  = 1'b1;
                                wr_link_en = 1'b1;
                                n_top      = r_idx[IDX_W-1:0];
                                n_nonempty = 1'b1;
                            end
                        end
                        default: begin
                            if (!in_region) begin
                                res_status = ghsa_pkg::ST_NOT_OPEN;
                            end else begin
                                res_gen = look_gen;
                                if (look_gen != r_gen) begin
                                    res_status = ghsa_pkg::ST_STALE;
                                end
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = ghsa_pkg::BK_READ;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ghsa_pkg::BK_READ;
            r_top      <= '0;
            r_nonempty <= 1'b0;
            r_opened   <= '0;
            r_region   <= '0;
            r_blk      <= '0;
        end else begin
            r_state    <= n_state;
            r_top      <= n_top;
            r_nonempty <= n_nonempty;
            r_opened   <= n_opened;
            r_region   <= n_region;
            r_blk      <= n_blk;
        end
    end

    // Latch the request being worked on.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_op  <= i_q_item.op;
            r_idx <= i_q_item.index;
            r_gen <= i_q_item.generation;
        end
    end

    // Memory read port, registered.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_gen_rd  <= r_gen_mem[rd_addr];
            r_link_rd <= r_link_mem[rd_addr];
        end
    end

    // Memory write ports.
    always_ff @(posedge i_clk) begin
        if (wr_gen_en) begin
            r_gen_mem[wr_addr] <= wr_gen_data;
        end
        if (wr_link_en) begin
            r_link_mem[wr_addr] <= {r_nonempty, r_top};
        end
    end

    // Response register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Response register payload.
    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out_status <= res_status;
            r_out_index  <= res_index;
            r_out_gen    <= res_gen;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.out_index      = r_out_index;
    assign o_rsp.out_generation = r_out_gen;
    assign o_stat.opened        = r_opened;
    assign o_stat.region        = r_region;

endmodule
